[rtl/core/s2i_pkg.sv]
package s2i_pkg;

   localparam int POSITION_BITS = 16;
   localparam int VALUE_BITS    = 64;
   localparam int CHARS_BITS    = 16;
   localparam int BASE_BITS     = 6;
   localparam int CHAR_BITS     = 8;

   localparam logic [BASE_BITS-1:0] BASE_RESET = BASE_BITS'(10);
   localparam logic [BASE_BITS-1:0] BASE_DEC   = BASE_BITS'(10);
   localparam logic [BASE_BITS-1:0] BASE_HEX   = BASE_BITS'(16);
   localparam logic [BASE_BITS-1:0] BASE_OCT   = BASE_BITS'(8);
   localparam logic [BASE_BITS-1:0] BASE_BIN   = BASE_BITS'(2);

   localparam logic [2:0] PH_SPACE  = 3'd0;
   localparam logic [2:0] PH_START  = 3'd1;
   localparam logic [2:0] PH_ZERO   = 3'd2;
   localparam logic [2:0] PH_PREFIX = 3'd3;
   localparam logic [2:0] PH_DIGITS = 3'd4;
   localparam logic [2:0] PH_DONE   = 3'd5;

   localparam logic [CHAR_BITS-1:0] NO_DIGIT = 8'hFF;

   localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_BITS-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_BITS-1:0] CH_LOW_X = 8'h78;
   localparam logic [CHAR_BITS-1:0] CH_LOW_B = 8'h62;
   localparam logic [CHAR_BITS-1:0] CASE_BIT = 8'h20;

   typedef struct packed {
      logic [2:0]               phase;
      logic                     negative;
      logic [BASE_BITS-1:0]     base;
      logic [VALUE_BITS-1:0]    acc;
      logic [POSITION_BITS-1:0] pos;
      logic                     digit_seen;
   } parse_state_type;

   typedef struct packed {
      logic [CHARS_BITS-1:0] chars_consumed;
      logic [VALUE_BITS-1:0] value;
   } result_type;

   function automatic logic [CHAR_BITS-1:0] digit_value(input logic [CHAR_BITS-1:0] c);
      logic [CHAR_BITS-1:0] d;
      begin
         if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
         end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = c - 8'h57;
         end else if (c >= 8'h41 && c <= 8'h5A) begin
            d = c - 8'h37;
         end else begin
            d = NO_DIGIT;
         end
         return d;
      end
   endfunction

endpackage

[rtl/core/s2i_step.sv]
module s2i_step
   import s2i_pkg::*;
(
   input  logic [BASE_BITS-1:0] number_base,
   input  logic [CHAR_BITS-1:0] char_in,
   input  parse_state_type      cur,
   output parse_state_type      nxt,
   output logic                 emit,
   output result_type           result
);

   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   logic [BASE_BITS-1:0]     start_base;
   logic [BASE_BITS-1:0]     eff_base;
   logic [CHAR_BITS-1:0]     dval;
   logic                     d_ok;
   logic [VALUE_BITS-1:0]    mac;
   logic [CHAR_BITS-1:0]     lower_c;
   logic [POSITION_BITS-1:0] end_pos;
   logic [VALUE_BITS-1:0]    emit_val;
   logic                     zero_prefix;

   // Before the PH_DIGITS phase the accumulator is still zero, so the
   // product only carries weight once a digit has been taken.
   assign mac = VALUE_BITS'(cur.acc * VALUE_BITS'(cur.base)) + VALUE_BITS'(dval);

   always_comb begin
      start_base  = (number_base == '0) ? BASE_DEC : number_base;
      eff_base    = ((cur.phase == PH_SPACE) || (cur.phase == PH_START)) ? start_base
                                                                          : cur.base;
      dval        = digit_value(char_in);
      d_ok        = (dval != NO_DIGIT) && (dval < CHAR_BITS'(eff_base));
      lower_c     = char_in | CASE_BIT;
      zero_prefix = (char_in == CH_ZERO) &&
                    ((number_base == '0) || (number_base == BASE_HEX) ||
                     (number_base == BASE_BIN));

      if (cur.phase == PH_DIGITS || cur.phase == PH_ZERO) begin
         end_pos = cur.pos;
      end else if (cur.phase == PH_PREFIX) begin
         end_pos = (cur.pos == POS_MAX || cur.pos == '0) ? cur.pos : cur.pos - 1'b1;
      end else begin
         end_pos = '0;
      end
      emit_val = cur.acc;
      if (!cur.digit_seen) begin
         emit_val = '0;
         end_pos  = '0;
      end
      if (cur.negative) begin
         emit_val = '0 - emit_val;
      end
      result.value          = emit_val;
      result.chars_consumed = CHARS_BITS'(end_pos);

      nxt  = cur;
      emit = 1'b0;
      if (char_in == CH_NUL) begin
         emit = (cur.phase < PH_DONE);
         nxt  = '0;
      end else begin
         unique case (cur.phase)
            PH_SPACE, PH_START: begin
               if (cur.phase == PH_SPACE &&
                   (char_in == CH_SPACE || char_in == CH_TAB ||
                    char_in == CH_LF || char_in == CH_CR)) begin
                  nxt.phase = PH_SPACE;
               end else if (cur.phase == PH_SPACE && char_in == CH_MINUS) begin
                  nxt.negative = 1'b1;
                  nxt.phase    = PH_START;
               end else if (cur.phase == PH_SPACE && char_in == CH_PLUS) begin
                  nxt.phase = PH_START;
               end else if (zero_prefix) begin
                  // A zero that may open a prefix counts as a digit already.
                  nxt.base       = (number_base == '0) ? BASE_OCT : number_base;
                  nxt.acc        = '0;
                  nxt.digit_seen = 1'b1;
                  nxt.phase      = PH_ZERO;
               end else begin
                  nxt.base = start_base;
                  if (d_ok) begin
                     nxt.acc        = VALUE_BITS'(dval);
                     nxt.digit_seen = 1'b1;
                     nxt.phase      = PH_DIGITS;
                  end else begin
                     emit      = 1'b1;
                     nxt.phase = PH_DONE;
                  end
               end
            end
            PH_ZERO, PH_PREFIX, PH_DIGITS: begin
               if (cur.phase == PH_ZERO && lower_c == CH_LOW_X &&
                   (cur.base == BASE_OCT || cur.base == BASE_HEX)) begin
                  nxt.base  = BASE_HEX;
                  nxt.phase = PH_PREFIX;
               end else if (cur.phase == PH_ZERO && lower_c == CH_LOW_B &&
                            (cur.base == BASE_OCT || cur.base == BASE_BIN)) begin
                  nxt.base  = BASE_BIN;
                  nxt.phase = PH_PREFIX;
               end else if (d_ok) begin
                  nxt.acc        = mac;
                  nxt.digit_seen = 1'b1;
                  nxt.phase      = PH_DIGITS;
               end else begin
                  emit      = 1'b1;
                  nxt.phase = PH_DONE;
               end
            end
            default: begin
               nxt.phase = cur.phase;
            end
         endcase
         if (cur.pos != POS_MAX) begin
            nxt.pos = cur.pos + 1'b1;
         end
      end
   end

endmodule

[rtl/core/string_to_int64_parser.sv]
// Streaming strtoll-style parser: one character per transfer on the req_
// channel, a zero byte ending each string. Blanks are skipped, one sign is
// taken, the radix comes from csr_wr_data (0 detects it from a 0x, 0b or 0
// prefix) and digits accumulate modulo 2^64.
// Exactly one result per string leaves on the rsp_ channel, at the first
// character that cannot continue the number (the zero byte included); it
// carries the signed value and the offset just past the last digit, or zero
// for both when no digit was found. Characters after it up to the zero byte
// are dropped.
// Throughput is one character per cycle while no result is stalled, set by
// the 64 by 6 bit multiply-accumulate that closes the accumulator loop.
// A character taken waits in the input register; the parse step that
// consumes it loads its result into the register that drives rsp_tdata.
// The radix register is sampled at the first character past blanks and sign.
// Reset returns the parser to the start of a string with radix 10.
// When the receiver holds rsp_tready low, the result register keeps its
// value, one more character waits in the input register, and then req_tready
// drops until the result is taken.
module string_to_int64_parser
   import s2i_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] char_in
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [79:0]          rsp_tdata,   // [63:0] value, [79:64] chars_consumed
   input  logic                 csr_wr_en,
   input  logic [BASE_BITS-1:0] csr_wr_data
);

   logic [BASE_BITS-1:0] base_ff, base_in;
   logic                 in_valid_ff, in_valid_in;
   logic [CHAR_BITS-1:0] in_char_ff, in_char_in;
   parse_state_type      state_ff, state_in;
   logic                 out_valid_ff, out_valid_in;
   result_type           out_data_ff, out_data_in;

   parse_state_type      step_nxt;
   logic                 step_emit;
   result_type           step_result;
   logic                 step_fire;
   logic                 req_xfer;

   s2i_step u_step (
      .number_base (base_ff),
      .char_in     (in_char_ff),
      .cur         (state_ff),
      .nxt         (step_nxt),
      .emit        (step_emit),
      .result      (step_result)
   );

   assign step_fire  = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step_fire;
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_comb begin
      base_in      = csr_wr_en ? csr_wr_data : base_ff;
      in_char_in   = req_xfer ? req_tdata : in_char_ff;
      in_valid_in  = req_xfer ? 1'b1 : (step_fire ? 1'b0 : in_valid_ff);
      state_in     = step_fire ? step_nxt : state_ff;
      out_data_in  = out_data_ff;
      out_valid_in = out_valid_ff;
      if (step_fire && step_emit) begin
         out_data_in  = step_result;
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= BASE_RESET;
         in_valid_ff  <= 1'b0;
         state_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff  <= in_char_in;
      out_data_ff <= out_data_in;
   end

   a_nul_rearms: assert property (@(posedge clock) disable iff (reset)
      step_fire && in_char_ff == CH_NUL |=> state_ff.phase == PH_SPACE &&
                                           state_ff.pos == '0)
      else $error("zero byte did not rearm the parser");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      step_fire && step_emit |-> state_ff.phase != PH_DONE)
      else $error("second result for one string");

   a_seen_phase: assert property (@(posedge clock) disable iff (reset)
      state_ff.digit_seen |-> state_ff.phase != PH_SPACE && state_ff.phase != PH_START)
      else $error("digit flagged before number start");

   a_digit_base: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_DIGITS |-> state_ff.base != '0)
      else $error("digits accumulated with zero radix");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |-> !step_fire)
      else $error("parse step advanced over a stalled result");

endmodule
